FILE: rtl/core/lcg64fnv_pkg.sv
// Shared types, constants and command codes for the LCG64 / FNV-1a seed block.
`timescale 1ns / 1ps
`default_nettype none

package lcg64fnv_pkg;

    // Generator and hash constants
    localparam logic [63:0] LCG_MUL      = 64'd6364136223846793005;
    localparam logic [63:0] LCG_ADD      = 64'd1442695040888963407;
    localparam logic [63:0] FNV_BASIS    = 64'd14695981039346656037;
    localparam logic [63:0] FNV_PRIME    = 64'd1099511628211;
    localparam logic [63:0] MASTER_RESET = 64'd12345;

    // Command codes carried in the request beat
    localparam logic [2:0] CMD_LOAD_SEED = 3'd0;
    localparam logic [2:0] CMD_NEXT64    = 3'd1;
    localparam logic [2:0] CMD_NEXT32    = 3'd2;
    localparam logic [2:0] CMD_RANGE     = 3'd3;
    localparam logic [2:0] CMD_BERNOULLI = 3'd4;
    localparam logic [2:0] CMD_KEY_BYTE  = 3'd5;

    // Configuration space
    localparam int          PADDR_W         = 4;
    localparam logic        REG_MASTER_SEED = 1'b0;

    // Divider iteration count, one quotient bit per cycle
    localparam logic [4:0]  DIV_LAST_STEP   = 5'd31;
    localparam logic [4:0]  MUL_LAST_STEP   = 5'd3;

    typedef struct packed {
        logic [2:0]         cmd;
        logic [63:0]        seed_value;
        logic signed [31:0] range_low;
        logic signed [31:0] range_high;
        logic [32:0]        probability;
        logic [7:0]         key_byte;
        logic               key_last;
        logic               use_master;
    } req_t;

    typedef struct packed {
        logic [63:0] value;
        logic        flag;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_MUL,
        ST_FIN,
        ST_DIV,
        ST_RFIN,
        ST_EMIT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic       latch;
        logic       seed_wr;
        logic       mul_init;
        logic       mul_step;
        logic [1:0] step;
        logic       fin;
        logic       div_step;
        logic       range_done;
        logic       empty_done;
        logic       emit;
    } ctrl_t;

    // Datapath to controller status
    typedef struct packed {
        logic [2:0] cmd;
        logic       range_empty;
        logic       key_last;
    } stat_t;

endpackage : lcg64fnv_pkg

`default_nettype wire

FILE: rtl/core/lcg64_random_with_fnv_seed_derive.sv
// Flow: decode, 4-step shared 32x32 multiply, finish, emit for next64/next32/bernoulli/last
// key byte; a non-empty range adds a 32-step divider and a range finish before emit, an empty
// range goes from decode to emit. Load seed writes the state in decode and a non-last key byte
// updates the hash at finish, neither with a result. Throughput: one item at a time; an
// earlier result may still wait in the output register, a stalled one delays the emit.
// Reset: rng state 0, hash at the FNV offset basis, master seed 12345, channels idle.
`timescale 1ns / 1ps
`default_nettype none

module lcg64_random_with_fnv_seed_derive (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire                                req_valid,
    output logic                               req_stall,
    input  lcg64fnv_pkg::req_t                 req,
    output logic                               rsp_valid,
    input  wire                                rsp_stall,
    output lcg64fnv_pkg::rsp_t                 rsp,
    input  wire                                psel,
    input  wire                                penable,
    input  wire                                pwrite,
    input  wire [lcg64fnv_pkg::PADDR_W-1:0]    paddr,
    input  wire [63:0]                         pwdata,
    output logic [63:0]                        prdata,
    output logic                               pready
);
    import lcg64fnv_pkg::*;

    ctrl_t       ctrl;
    stat_t       stat;
    logic        cfg_wr;
    logic [63:0] master_seed;

    // Decode register writes on the access phase
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[PADDR_W-1] == REG_MASTER_SEED);
    assign prdata = (paddr[PADDR_W-1] == REG_MASTER_SEED) ? master_seed : '0;

    lcg64fnv_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .stat      (stat),
        .ctrl      (ctrl)
    );

    lcg64fnv_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .ctrl        (ctrl),
        .stat        (stat),
        .rsp         (rsp),
        .cfg_wr      (cfg_wr),
        .cfg_data    (pwdata),
        .master_seed (master_seed)
    );

endmodule : lcg64_random_with_fnv_seed_derive

`default_nettype wire

FILE: rtl/core/lcg64fnv_ctrl.sv
// Sequencing state machine: handshakes, multiply and divide step counting.
`timescale 1ns / 1ps
`default_nettype none

module lcg64fnv_ctrl (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    input  lcg64fnv_pkg::stat_t stat,
    output lcg64fnv_pkg::ctrl_t ctrl
);
    import lcg64fnv_pkg::*;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       rsp_valid_reg, rsp_valid_next;

    // State, step counter and output valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Next state and datapath commands
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ctrl       = '0;
        ctrl.step  = cnt_reg[1:0];
        req_stall  = 1'b1;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_stall = 1'b0;
                if (req_valid)
                begin
                    ctrl.latch = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cnt_next = '0;
                priority if (stat.cmd == CMD_LOAD_SEED)
                begin
                    ctrl.seed_wr = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (stat.cmd == CMD_RANGE && stat.range_empty)
                begin
                    ctrl.empty_done = 1'b1;
                    state_next      = ST_EMIT;
                end
                else if (stat.cmd == CMD_NEXT64 || stat.cmd == CMD_NEXT32 ||
                         stat.cmd == CMD_RANGE || stat.cmd == CMD_BERNOULLI ||
                         stat.cmd == CMD_KEY_BYTE)
                begin
                    ctrl.mul_init = 1'b1;
                    state_next    = ST_MUL;
                end
                else
                begin
                    // Drop unused command codes
                    state_next = ST_IDLE;
                end
            end
            ST_MUL:
            begin
                ctrl.mul_step = 1'b1;
                if (cnt_reg == MUL_LAST_STEP)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_FIN:
            begin
                ctrl.fin = 1'b1;
                cnt_next = '0;
                priority if (stat.cmd == CMD_KEY_BYTE && !stat.key_last)
                    state_next = ST_IDLE;
                else if (stat.cmd == CMD_RANGE)
                    state_next = ST_DIV;
                else
                    state_next = ST_EMIT;
            end
            ST_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (cnt_reg == DIV_LAST_STEP)
                begin
                    state_next = ST_RFIN;
                end
                else
                begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            ST_RFIN:
            begin
                ctrl.range_done = 1'b1;
                state_next      = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Hand the result over once the output register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    ctrl.emit  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold valid while stalled, set on a new result
    always_comb
    begin
        rsp_valid_next = ctrl.emit ? 1'b1 : (rsp_valid_reg && rsp_stall);
    end

    assign rsp_valid = rsp_valid_reg;

endmodule : lcg64fnv_ctrl

`default_nettype wire

FILE: rtl/core/lcg64fnv_dp.sv
// Datapath: generator and hash state, shared 32x32 multiplier, bit-serial divider.
`timescale 1ns / 1ps
`default_nettype none

module lcg64fnv_dp (
    input  wire                 clk,
    input  wire                 rst_n,
    input  lcg64fnv_pkg::req_t  req,
    input  lcg64fnv_pkg::ctrl_t ctrl,
    output lcg64fnv_pkg::stat_t stat,
    output lcg64fnv_pkg::rsp_t  rsp,
    input  wire                 cfg_wr,
    input  wire [63:0]          cfg_data,
    output logic [63:0]         master_seed
);
    import lcg64fnv_pkg::*;

    // Architectural state
    logic [63:0] rng_reg, rng_next;
    logic [63:0] hash_reg, hash_next;
    logic [63:0] master_reg;

    // Working registers
    req_t        item_reg;
    logic [63:0] op_a_reg, op_b_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [31:0] span_reg;
    logic [31:0] dvd_reg;
    logic [32:0] rem_reg;
    logic [63:0] res_value_reg;
    logic        res_flag_reg;
    rsp_t        rsp_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] prod_next;
    logic [63:0] adv;
    logic [32:0] rem_sh;

    // Shared multiplier: pick the 32-bit halves for this partial product
    always_comb
    begin
        unique case (ctrl.step)
            2'd0:
            begin
                mul_a = op_a_reg[31:0];
                mul_b = op_b_reg[31:0];
            end
            2'd1:
            begin
                mul_a = op_a_reg[31:0];
                mul_b = op_b_reg[63:32];
            end
            default:
            begin
                mul_a = op_a_reg[63:32];
                mul_b = op_b_reg[31:0];
            end
        endcase
        prod_next = {32'd0, mul_a} * {32'd0, mul_b};
    end

    assign adv    = acc_reg + LCG_ADD;
    assign rem_sh = {rem_reg[31:0], dvd_reg[31]};

    // Generator and hash state updates
    always_comb
    begin
        rng_next  = rng_reg;
        hash_next = hash_reg;
        if (ctrl.seed_wr)
        begin
            rng_next = item_reg.seed_value;
        end
        if (ctrl.fin)
        begin
            if (item_reg.cmd == CMD_KEY_BYTE)
            begin
                hash_next = item_reg.key_last ? FNV_BASIS : acc_reg;
            end
            else
            begin
                rng_next = adv;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rng_reg    <= '0;
            hash_reg   <= FNV_BASIS;
            master_reg <= MASTER_RESET;
        end
        else
        begin
            rng_reg  <= rng_next;
            hash_reg <= hash_next;
            if (cfg_wr)
            begin
                master_reg <= cfg_data;
            end
        end
    end

    // Capture the request beat
    always_ff @(posedge clk)
    begin
        if (ctrl.latch)
        begin
            item_reg <= req;
        end
    end

    // Load multiplier operands and accumulate partial products
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_init)
        begin
            if (item_reg.cmd == CMD_KEY_BYTE)
            begin
                op_a_reg <= hash_reg ^ {56'd0, item_reg.key_byte};
                op_b_reg <= FNV_PRIME;
            end
            else
            begin
                op_a_reg <= rng_reg;
                op_b_reg <= LCG_MUL;
            end
        end
        if (ctrl.mul_step)
        begin
            prod_reg <= prod_next;
            unique case (ctrl.step)
                2'd0:    acc_reg <= acc_reg;
                2'd1:    acc_reg <= prod_reg;
                default: acc_reg <= acc_reg + {prod_reg[31:0], 32'd0};
            endcase
        end
    end

    // Result, divider setup and restoring division steps
    always_ff @(posedge clk)
    begin
        if (ctrl.empty_done)
        begin
            res_value_reg <= {32'd0, item_reg.range_low};
            res_flag_reg  <= 1'b0;
        end
        if (ctrl.fin)
        begin
            res_flag_reg <= 1'b0;
            unique case (item_reg.cmd)
                CMD_KEY_BYTE:
                    res_value_reg <= acc_reg ^ (item_reg.use_master ? master_reg : rng_reg);
                CMD_NEXT32:
                    res_value_reg <= {32'd0, adv[63:32]};
                CMD_BERNOULLI:
                begin
                    res_value_reg <= '0;
                    res_flag_reg  <= ({1'b0, adv[63:32]} < item_reg.probability);
                end
                default:
                    res_value_reg <= adv;
            endcase
            span_reg <= item_reg.range_high - item_reg.range_low;
            dvd_reg  <= adv[63:32];
            rem_reg  <= '0;
        end
        if (ctrl.div_step)
        begin
            dvd_reg <= {dvd_reg[30:0], 1'b0};
            if (rem_sh >= {1'b0, span_reg})
                rem_reg <= rem_sh - {1'b0, span_reg};
            else
                rem_reg <= rem_sh;
        end
        if (ctrl.range_done)
        begin
            res_value_reg <= {32'd0, item_reg.range_low + rem_reg[31:0]};
            res_flag_reg  <= 1'b0;
        end
        if (ctrl.emit)
        begin
            rsp_reg.value <= res_value_reg;
            rsp_reg.flag  <= res_flag_reg;
        end
    end

    assign stat.cmd         = item_reg.cmd;
    assign stat.range_empty = (item_reg.range_high <= item_reg.range_low);
    assign stat.key_last    = item_reg.key_last;
    assign rsp              = rsp_reg;
    assign master_seed      = master_reg;

endmodule : lcg64fnv_dp

`default_nettype wire

FILE: rtl/core/lcg64fnv_chk.sv
// Port-level checker for the LCG64 / FNV seed block and its bind.
`timescale 1ns / 1ps
`default_nettype none

module lcg64fnv_chk (
    input wire                             clk,
    input wire                             rst_n,
    input wire                             req_valid,
    input wire                             req_stall,
    input wire                             rsp_valid,
    input wire                             rsp_stall,
    input lcg64fnv_pkg::rsp_t              rsp
);
    import lcg64fnv_pkg::*;

    // Hold a stalled result beat
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid)
        else $error("result beat dropped while stalled");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> $stable(rsp))
        else $error("stalled result payload changed");

    // An accepted beat keeps the block busy for at least the decode cycle
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && !req_stall |=> req_stall)
        else $error("request taken while previous beat still decoding");

    // A new result only appears after the block was busy
    a_rsp_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp_valid) |-> $past(req_stall))
        else $error("result appeared without a busy cycle");

    // A Bernoulli hit carries a zero value word
    a_flag_value: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.flag |-> (rsp.value == 64'd0))
        else $error("flag set with nonzero value");

endmodule : lcg64fnv_chk

bind lcg64_random_with_fnv_seed_derive lcg64fnv_chk u_lcg64fnv_chk (.*);

`default_nettype wire

FILE: test/lcg64_fnv_checker.sv
// Checker for the LCG64 / FNV-1a seed block: predicts each result beat and compares it.
`timescale 1ns / 1ps

module lcg64_fnv_checker
    import lcg64fnv_pkg::*;
#(
    parameter logic [PADDR_W-1:0] MASTER_ADDR = '0
) (
    input  wire                clk,
    input  wire                rst_n,
    input  wire                req_valid,
    input  wire                req_stall,
    input  req_t               req,
    input  wire                rsp_valid,
    input  wire                rsp_stall,
    input  rsp_t               rsp,
    input  wire                psel,
    input  wire                penable,
    input  wire                pwrite,
    input  wire [PADDR_W-1:0]  paddr,
    input  wire [63:0]         pwdata,
    input  wire                pready,
    output int                 mismatches,
    output int                 pending_results
);

    // Predicted block state
    logic [63:0] gen_state;
    logic [63:0] key_hash;
    logic [63:0] master_copy;

    // Results still owed by the block, oldest first
    rsp_t draws_due[$];

    initial
    begin
        mismatches      = 0;
        pending_results = 0;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("%0t ns: mismatch on %s: got %h, expected %h", $time, what, got, want);
        mismatches++;
    endtask

    function automatic logic [63:0] advance_generator();
        gen_state = gen_state * LCG_MUL + LCG_ADD;
        return gen_state;
    endfunction

    // Apply one request beat to the predicted state; return 1 when it yields a result
    function automatic bit predict_draw(input req_t r, output rsp_t d);
        logic [31:0] word;
        logic [31:0] span;
        logic [31:0] offset;
        d = '0;
        case (r.cmd)
            CMD_LOAD_SEED:
            begin
                gen_state = r.seed_value;
                return 1'b0;
            end
            CMD_NEXT64:
                d.value = advance_generator();
            CMD_NEXT32:
            begin
                word    = 32'(advance_generator() >> 32);
                d.value = {32'd0, word};
            end
            CMD_RANGE:
            begin
                if (r.range_high <= r.range_low)
                    d.value = {32'd0, r.range_low};
                else
                begin
                    span    = r.range_high - r.range_low;
                    word    = 32'(advance_generator() >> 32);
                    offset  = word % span;
                    word    = r.range_low + offset;
                    d.value = {32'd0, word};
                end
            end
            CMD_BERNOULLI:
            begin
                word   = 32'(advance_generator() >> 32);
                d.flag = ({1'b0, word} < r.probability);
            end
            CMD_KEY_BYTE:
            begin
                key_hash = (key_hash ^ {56'd0, r.key_byte}) * FNV_PRIME;
                if (!r.key_last)
                    return 1'b0;
                d.value  = key_hash ^ (r.use_master ? master_copy : gen_state);
                key_hash = FNV_BASIS;
            end
            default:
                return 1'b0;
        endcase
        return 1'b1;
    endfunction

    // Watch config writes, result beats and request beats
    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        rsp_t due;
        if (!rst_n)
        begin
            gen_state   = '0;
            key_hash    = FNV_BASIS;
            master_copy = MASTER_RESET;
            draws_due.delete();
            pending_results = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == MASTER_ADDR)
                master_copy = pwdata;

            if (rsp_valid && !rsp_stall)
            begin
                if (draws_due.size() == 0)
                    report_mismatch("unexpected result beat", rsp.value, 64'd0);
                else
                begin
                    want = draws_due.pop_front();
                    if (rsp.value !== want.value)
                        report_mismatch("value", rsp.value, want.value);
                    if (rsp.flag !== want.flag)
                        report_mismatch("flag", {63'd0, rsp.flag}, {63'd0, want.flag});
                end
            end

            if (req_valid && !req_stall)
            begin
                if (predict_draw(req, due))
                    draws_due = {draws_due, due};
            end

            pending_results = draws_due.size();
        end
    end

endmodule

FILE: test/tb_lcg64_random_with_fnv_seed_derive.sv
// Testbench top for the LCG64 / FNV-1a seed block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_lcg64_random_with_fnv_seed_derive;
    import lcg64fnv_pkg::*;

    localparam logic [PADDR_W-1:0] MASTER_SEED_ADDR = PADDR_W'(8 * REG_MASTER_SEED);
    localparam logic [2:0]         CMD_SPARE_A      = 3'd6;
    localparam logic [2:0]         CMD_SPARE_B      = 3'd7;
    localparam int                 ITEMS_PER_PHASE  = 300;
    localparam int                 NUM_PHASES       = 6;

    logic               clk;
    logic               rst_n;
    logic               req_valid;
    logic               req_stall;
    req_t               req_beat;
    logic               rsp_valid;
    logic               rsp_stall;
    rsp_t               rsp_beat;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [63:0]        pwdata;
    logic [63:0]        prdata;
    logic               pready;

    int                 mismatches;
    int                 pending_results;

    // Idle shaping for the sender, plus flags shared with the receiver
    int                 tx_odds;
    int                 beats_in_mode;
    bit                 last_stretch;
    bit                 rx_hold_request;

    lcg64_random_with_fnv_seed_derive uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req_beat),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp_beat),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    lcg64_fnv_checker #(
        .MASTER_ADDR (MASTER_SEED_ADDR)
    ) u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_stall       (req_stall),
        .req             (req_beat),
        .rsp_valid       (rsp_valid),
        .rsp_stall       (rsp_stall),
        .rsp             (rsp_beat),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .pending_results (pending_results)
    );

    // 100 MHz clock
    initial
        clk = 1'b0;
    always #5 clk = ~clk;

    // Hard stop well past the slowest legal run
    initial
    begin
        #10_000_000;
        $display("Simulation FAILED");
        $finish;
    end

    // Receiver: random stall bursts, calm stretches, and one long hold-off on request
    initial
    begin
        int rx_odds;
        int cycles_in_mode;
        rsp_stall      = 1'b0;
        rx_odds        = 0;
        cycles_in_mode = 0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (cycles_in_mode == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       rx_odds = 0;
                    1:       rx_odds = 3;
                    default: rx_odds = 10;
                endcase
                cycles_in_mode = 64;
            end
            cycles_in_mode--;
            if (rx_hold_request)
            begin
                rsp_stall = 1'b1;
                repeat (400) @(negedge clk);
                rsp_stall       = 1'b0;
                rx_hold_request = 1'b0;
            end
            else if (!last_stretch && rx_odds != 0 && $urandom_range(1, rx_odds) == 1)
            begin
                rsp_stall = 1'b1;
                repeat ($urandom_range(1, 16) - 1) @(negedge clk);
            end
            else
                rsp_stall = 1'b0;
        end
    end

    function automatic req_t random_req(input logic [2:0] cmd);
        req_t r;
        r.cmd         = cmd;
        r.seed_value  = {$urandom(), $urandom()};
        r.range_low   = $urandom();
        r.range_high  = $urandom();
        r.probability = {1'($urandom_range(0, 1)), $urandom()};
        r.key_byte    = 8'($urandom());
        r.key_last    = 1'($urandom());
        r.use_master  = 1'($urandom());
        return r;
    endfunction

    // Offer one beat at the falling edge, hold it until taken, return at the next falling edge
    task automatic offer_beat(input req_t r);
        if (beats_in_mode == 0)
        begin
            case ($urandom_range(0, 2))
                0:       tx_odds = 0;
                1:       tx_odds = 3;
                default: tx_odds = 10;
            endcase
            beats_in_mode = 40;
        end
        beats_in_mode--;
        if (!last_stretch && tx_odds != 0 && $urandom_range(1, tx_odds) == 1)
        begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 16)) @(negedge clk);
        end
        req_beat  = r;
        req_valid = 1'b1;
        do
            @(posedge clk);
        while (req_stall);
        @(negedge clk);
    endtask

    task automatic write_master_seed(input logic [63:0] seed);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = MASTER_SEED_ADDR;
        pwdata  = seed;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    // Drop valid, drain all results, then let a beat with no result retire
    task automatic drain_block();
        req_valid = 1'b0;
        wait (pending_results == 0);
        repeat (64) @(negedge clk);
    endtask

    task automatic offer_range(input logic [31:0] lo, input logic [31:0] hi);
        req_t r;
        r            = random_req(CMD_RANGE);
        r.range_low  = lo;
        r.range_high = hi;
        offer_beat(r);
    endtask

    task automatic offer_bernoulli(input logic [32:0] prob);
        req_t r;
        r             = random_req(CMD_BERNOULLI);
        r.probability = prob;
        offer_beat(r);
    endtask

    task automatic offer_key(input logic [7:0] b, input bit last, input bit master);
        req_t r;
        r            = random_req(CMD_KEY_BYTE);
        r.key_byte   = b;
        r.key_last   = last;
        r.use_master = master;
        offer_beat(r);
    endtask

    task automatic offer_seed(input logic [63:0] seed);
        req_t r;
        r            = random_req(CMD_LOAD_SEED);
        r.seed_value = seed;
        offer_beat(r);
    endtask

    // Random traffic: mostly well-formed commands and key strings, some noise
    task automatic run_random(input int n_items);
        int   sent;
        int   pick;
        int   len;
        req_t r;
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 5)
            begin
                r = random_req(CMD_LOAD_SEED);
                case ($urandom_range(0, 5))
                    0:       r.seed_value = '0;
                    1:       r.seed_value = '1;
                    default: ;
                endcase
                offer_beat(r);
                sent++;
            end
            else if (pick < 20)
            begin
                offer_beat(random_req($urandom_range(0, 1) ? CMD_NEXT64 : CMD_NEXT32));
                sent++;
            end
            else if (pick < 45)
            begin
                r = random_req(CMD_RANGE);
                case ($urandom_range(0, 5))
                    0: r.range_high = r.range_low + $urandom_range(1, 40);
                    1: r.range_high = r.range_low;
                    2:
                    begin
                        r.range_low  = 32'h8000_0000 + $urandom_range(0, 3);
                        r.range_high = 32'h7FFF_FFFF - $urandom_range(0, 3);
                    end
                    3:
                    begin
                        r.range_low  = -$urandom_range(0, 100);
                        r.range_high = $urandom_range(0, 100);
                    end
                    default: ;
                endcase
                offer_beat(r);
                sent++;
            end
            else if (pick < 60)
            begin
                r = random_req(CMD_BERNOULLI);
                case ($urandom_range(0, 5))
                    0: r.probability = {1'b0, $urandom()};
                    1: r.probability = {1'b0, $urandom()};
                    2: r.probability = $urandom_range(0, 1) ? 33'h1_0000_0000 : 33'd0;
                    default: ;
                endcase
                offer_beat(r);
                sent++;
            end
            else if (pick < 97)
            begin
                len = ($urandom_range(0, 3) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                begin
                    // occasionally break the key string with a draw
                    if (i != 0 && $urandom_range(0, 9) == 0)
                    begin
                        offer_beat(random_req(CMD_NEXT64));
                        sent++;
                    end
                    r          = random_req(CMD_KEY_BYTE);
                    r.key_last = (i == len - 1);
                    offer_beat(r);
                    sent++;
                end
            end
            else
                offer_beat(random_req($urandom_range(0, 1) ? CMD_SPARE_A : CMD_SPARE_B));
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [63:0] master_plan [NUM_PHASES];
        rst_n           = 1'b0;
        req_valid       = 1'b0;
        req_beat        = '0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        tx_odds         = 0;
        beats_in_mode   = 0;
        last_stretch    = 1'b0;
        rx_hold_request = 1'b0;

        master_plan[0] = 64'd0;
        master_plan[1] = 64'hFFFF_FFFF_FFFF_FFFF;
        master_plan[2] = {$urandom(), $urandom()};
        master_plan[3] = 64'd1;
        master_plan[4] = {$urandom(), $urandom()};
        master_plan[5] = MASTER_RESET;

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: hashing from reset, draws from zero state, edge ranges and odds
        offer_key(8'h00, 1'b1, 1'b0);
        offer_key(8'hFF, 1'b1, 1'b1);
        offer_beat(random_req(CMD_NEXT64));
        offer_beat(random_req(CMD_NEXT32));
        offer_seed(64'hFFFF_FFFF_FFFF_FFFF);
        offer_beat(random_req(CMD_NEXT64));
        offer_bernoulli(33'd0);
        offer_bernoulli(33'h1_0000_0000);
        offer_bernoulli(33'h1_FFFF_FFFF);
        offer_bernoulli(33'd1);
        offer_range(32'd5, 32'd5);
        offer_range(32'h7FFF_FFFF, 32'h8000_0000);
        offer_range(32'h8000_0000, 32'h7FFF_FFFF);
        offer_range(32'hFFFF_FFFF, 32'd0);
        offer_range(32'd0, 32'h7FFF_FFFF);
        offer_seed(64'd0);
        offer_range(-32'sd10, 32'sd10);
        offer_key(8'h80, 1'b0, 1'b1);
        offer_key(8'h01, 1'b0, 1'b0);
        offer_key(8'hFF, 1'b1, 1'b0);
        offer_beat(random_req(CMD_SPARE_A));
        offer_beat(random_req(CMD_SPARE_B));
        offer_beat(random_req(CMD_NEXT32));

        // Random phases, each under its own master seed
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            drain_block();
            write_master_seed(master_plan[p]);
            if (p == 1)
                rx_hold_request = 1'b1;
            if (p == NUM_PHASES - 1)
                last_stretch = 1'b1;
            run_random(ITEMS_PER_PHASE);
        end

        req_valid = 1'b0;
        wait (pending_results == 0);
        repeat (64) @(posedge clk);
        if (mismatches == 0 && pending_results == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
rtl/core/lcg64fnv_pkg.sv
rtl/core/lcg64fnv_ctrl.sv
rtl/core/lcg64fnv_dp.sv
rtl/core/lcg64_random_with_fnv_seed_derive.sv
rtl/core/lcg64fnv_chk.sv
test/lcg64_fnv_checker.sv
test/tb_lcg64_random_with_fnv_seed_derive.sv
